// ----- rtl/dat_pkg.sv -----
// Package: shared widths, register indexes and divider handshake types.
package dat_pkg;

    localparam int BLK_W      = 32;
    localparam int CNT_W      = 16;
    localparam int HEAD_W     = 8;
    localparam int SPT_W      = 12;
    localparam int TRK_W      = 20;
    localparam int TIME_W     = 24;
    localparam int OUT_W      = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // shared divider: left-aligned dividend, divisor up to one cylinder
    localparam int DIVD_W = 64;
    localparam int DVSR_W = 20;
    localparam int STEP_W = 7;

    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 24;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 58;

    localparam int TRACK_BITS_DEF  = 20;
    localparam int SECTOR_BITS_DEF = 12;

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BLOCKS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAD_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECTORS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_COUNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AVG_SEEK     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_SEEK   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATION     = 3'd6;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [DIVD_W-1:0] dividend;
        logic [DVSR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quot;
        logic [DVSR_W-1:0] rem;
    } t_div_rsp;

endpackage

// ----- rtl/dat_if.sv -----
// Interfaces: request, response and configuration channels.
interface dat_req_if import dat_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [BLK_W-1:0] start_block;
    logic [CNT_W-1:0] block_count;
    modport source(output valid, start_block, block_count, input ready);
    modport sink(input valid, start_block, block_count, output ready);
endinterface

interface dat_rsp_if import dat_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             status;
    logic [OUT_W-1:0] access_time;
    modport source(output valid, status, access_time, input ready);
    modport sink(input valid, status, access_time, output ready);
endinterface

interface dat_cfg_if import dat_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/disk_access_time_model.sv -----
// Top level: disk seek and rotational latency model with request sequencer.
//
// Use: load the geometry and timing registers over i_cfg (index 0..6, write
// while no request is in flight; unknown indexes are dropped). Then send
// requests on i_req (start_block, block_count); each request gives exactly
// one item on o_rsp (status, access_time, 8 fraction bits).
// A request is taken only while the sequencer is idle. An empty request or
// one that runs past capacity is answered with status 1 and time 0 and
// leaves the head position alone. A valid request walks one shared
// restoring divider (one bit per cycle) and one registered 32x24
// multiplier through eight divisions. The result sits in an output
// register; if the receiver stalls, the sequencer holds in its final
// state until that register frees up, so at most one finished item
// waits. Reset (synchronous, active low) restores the default geometry
// (every count 1, times 1.0) and parks the head at track 0, sector 0.
module disk_access_time_model import dat_pkg::*; #(
    parameter int TRACK_BITS  = TRACK_BITS_DEF,
    parameter int SECTOR_BITS = SECTOR_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dat_req_if.sink   i_req,
    dat_rsp_if.source o_rsp,
    dat_cfg_if.sink   i_cfg
);

    // one-hot sequencer; W* states wait on a division, and all but W4 and W7 launch the next
    typedef enum logic [15:0] {
        S_IDLE = 16'b0000_0000_0000_0001,
        S_CYL  = 16'b0000_0000_0000_0010,  // cylinder size = heads * sectors
        S_L0   = 16'b0000_0000_0000_0100,  // start / cyl
        S_W0   = 16'b0000_0000_0000_1000,  // -> start rem % spt
        S_W1   = 16'b0000_0000_0001_0000,  // -> last / cyl
        S_W2   = 16'b0000_0000_0010_0000,  // -> last rem % spt
        S_W3   = 16'b0000_0000_0100_0000,  // -> head sector % spt
        S_W4   = 16'b0000_0000_1000_0000,  // rotational distance
        S_M0   = 16'b0000_0001_0000_0000,  // hop * avg seek
        S_M1   = 16'b0000_0010_0000_0000,  // -> far seek divide, hop * track seek
        S_M2   = 16'b0000_0100_0000_0000,  // keep near seek, track span * track seek
        S_M3   = 16'b0000_1000_0000_0000,  // rotation * distance
        S_W5   = 16'b0001_0000_0000_0000,  // seek = min, -> rotation / spt
        S_W6   = 16'b0010_0000_0000_0000,  // -> transfer / spt
        S_W7   = 16'b0100_0000_0000_0000,  // add transfer
        S_FIN  = 16'b1000_0000_0000_0000   // hand over result
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [BLK_W-1:0]  r_total;
    logic [HEAD_W-1:0] r_heads;
    logic [SPT_W-1:0]  r_spt;
    logic [TRK_W-1:0]  r_tracks;
    logic [TIME_W-1:0] r_avg_seek;
    logic [TIME_W-1:0] r_trk_seek;
    logic [TIME_W-1:0] r_rot_time;

    // head position
    logic [TRACK_BITS-1:0]  r_head_track;
    logic [SECTOR_BITS-1:0] r_head_sector;

    // request working set
    logic [BLK_W-1:0]  r_start;
    logic [BLK_W-1:0]  r_last;
    logic [CNT_W-1:0]  r_cnt;
    logic [DVSR_W-1:0] r_cyl;
    logic [BLK_W-1:0]  r_t0;
    logic [BLK_W-1:0]  r_t1;
    logic [SPT_W-1:0]  r_s0;
    logic [SPT_W-1:0]  r_s1;
    logic [BLK_W-1:0]  r_hop;
    logic [BLK_W-1:0]  r_dt;
    logic [SPT_W-1:0]  r_diff;
    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] r_near;
    logic [ACC_W-1:0]  r_acc;
    logic              r_status;

    // output register
    logic             r_out_valid;
    logic             r_out_status;
    logic [OUT_W-1:0] r_out_time;

    logic [HEAD_W-1:0]  heads_eff;
    logic [SPT_W-1:0]   spt_eff;
    logic [TRK_W-1:0]   tracks_eff;
    logic               req_fire;
    logic               range_err;
    logic               out_load;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [BLK_W-1:0]   head_track_ext;
    logic [SPT_W-1:0]   cur_sector;
    logic [PROD_W:0]    near_seek;
    logic [PROD_W:0]    far_seek;
    logic [PROD_W:0]    seek;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    // zero geometry behaves as one
    assign heads_eff  = (r_heads == '0) ? HEAD_W'(1) : r_heads;
    assign spt_eff    = (r_spt == '0) ? SPT_W'(1) : r_spt;
    assign tracks_eff = (r_tracks == '0) ? TRK_W'(1) : r_tracks;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;
    // exact 33-bit end, no wrap
    assign range_err   = (i_req.block_count == '0) ||
        (({1'b0, i_req.start_block} + (BLK_W+1)'(i_req.block_count)) > {1'b0, r_total});

    assign out_load = (r_state == S_FIN) && (!r_out_valid || o_rsp.ready);

    assign i_cfg.ready = 1'b1;

    assign head_track_ext = BLK_W'(r_head_track);
    assign cur_sector     = div_rsp.rem[SPT_W-1:0];
    assign near_seek      = (PROD_W+1)'(r_near);
    assign far_seek       = div_rsp.quot[PROD_W:0];
    assign seek           = (near_seek < far_seek) ? near_seek : far_seek;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= BLK_W'(1);
            r_heads    <= HEAD_W'(1);
            r_spt      <= SPT_W'(1);
            r_tracks   <= TRK_W'(1);
            r_avg_seek <= TIME_W'(256);
            r_trk_seek <= TIME_W'(256);
            r_rot_time <= TIME_W'(256);
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_TOTAL_BLOCKS: r_total    <= i_cfg.data[BLK_W-1:0];
                REG_HEAD_COUNT:   r_heads    <= i_cfg.data[HEAD_W-1:0];
                REG_SECTORS:      r_spt      <= i_cfg.data[SPT_W-1:0];
                REG_TRACK_COUNT:  r_tracks   <= i_cfg.data[TRK_W-1:0];
                REG_AVG_SEEK:     r_avg_seek <= i_cfg.data[TIME_W-1:0];
                REG_TRACK_SEEK:   r_trk_seek <= i_cfg.data[TIME_W-1:0];
                REG_ROTATION:     r_rot_time <= i_cfg.data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_CYL: begin
                mul_a = MUL_A_W'(heads_eff);
                mul_b = MUL_B_W'(spt_eff);
            end
            S_M0: begin
                mul_a = r_hop;
                mul_b = r_avg_seek;
            end
            S_M1: begin
                mul_a = r_hop;
                mul_b = r_trk_seek;
            end
            S_M2: begin
                mul_a = r_dt;
                mul_b = r_trk_seek;
            end
            S_M3, S_W5: begin
                mul_a = MUL_A_W'(r_diff);
                mul_b = r_rot_time;
            end
            S_W6: begin
                mul_a = MUL_A_W'(r_cnt);
                mul_b = r_rot_time;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // divider launches; dividends are left-aligned to the step count
    always_comb begin
        div_req          = '0;
        div_req.divisor  = DVSR_W'(spt_eff);
        unique case (r_state)
            S_L0: begin
                div_req.start    = 1'b1;
                div_req.steps    = STEP_W'(BLK_W);
                div_req.dividend = {r_start, {(DIVD_W-BLK_W){1'b0}}};
                div_req.divisor  = r_prod[DVSR_W-1:0];
            end
            S_W0, S_W2: begin
                div_req.start    = div_rsp.done;
                div_req.steps    = STEP_W'(DVSR_W);
                div_req.dividend = {div_rsp.rem, {(DIVD_W-DVSR_W){1'b0}}};
            end
            S_W1: begin
                div_req.start    = div_rsp.done;
                div_req.steps    = STEP_W'(BLK_W);
                div_req.dividend = {r_last, {(DIVD_W-BLK_W){1'b0}}};
                div_req.divisor  = r_cyl;
            end
            S_W3: begin
                div_req.start    = div_rsp.done;
                div_req.steps    = STEP_W'(SECTOR_BITS);
                div_req.dividend = {r_head_sector, {(DIVD_W-SECTOR_BITS){1'b0}}};
            end
            S_M1: begin
                // 2 * hop * avg over track count
                div_req.start    = 1'b1;
                div_req.steps    = STEP_W'(PROD_W + 1);
                div_req.dividend = {r_prod, 1'b0, {(DIVD_W-PROD_W-1){1'b0}}};
                div_req.divisor  = DVSR_W'(tracks_eff);
            end
            S_W5: begin
                div_req.start    = div_rsp.done;
                div_req.steps    = STEP_W'(TIME_W + SPT_W);
                div_req.dividend = {r_prod[TIME_W+SPT_W-1:0],
                                    {(DIVD_W-TIME_W-SPT_W){1'b0}}};
            end
            S_W6: begin
                div_req.start    = div_rsp.done;
                div_req.steps    = STEP_W'(TIME_W + CNT_W);
                div_req.dividend = {r_prod[TIME_W+CNT_W-1:0],
                                    {(DIVD_W-TIME_W-CNT_W){1'b0}}};
            end
            default: ;
        endcase
    end

    dat_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (req_fire) n_state = range_err ? S_FIN : S_CYL;
            S_CYL:  n_state = S_L0;
            S_L0:   n_state = S_W0;
            S_W0:   if (div_rsp.done) n_state = S_W1;
            S_W1:   if (div_rsp.done) n_state = S_W2;
            S_W2:   if (div_rsp.done) n_state = S_W3;
            S_W3:   if (div_rsp.done) n_state = S_W4;
            S_W4:   if (div_rsp.done) n_state = S_M0;
            S_M0:   n_state = S_M1;
            S_M1:   n_state = S_M2;
            S_M2:   n_state = S_M3;
            S_M3:   n_state = S_W5;
            S_W5:   if (div_rsp.done) n_state = S_W6;
            S_W6:   if (div_rsp.done) n_state = S_W7;
            S_W7:   if (div_rsp.done) n_state = S_FIN;
            S_FIN:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // request datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_start  <= i_req.start_block;
                r_cnt    <= i_req.block_count;
                r_last   <= i_req.start_block + BLK_W'(i_req.block_count) - 1'b1;
                r_status <= range_err;
                r_acc    <= '0;
            end
            S_L0: r_cyl <= r_prod[DVSR_W-1:0];
            S_W0: if (div_rsp.done) r_t0 <= div_rsp.quot[BLK_W-1:0];
            S_W1: if (div_rsp.done) r_s0 <= div_rsp.rem[SPT_W-1:0];
            S_W2: begin
                r_hop <= (r_t0 >= head_track_ext) ? r_t0 - head_track_ext
                                                  : head_track_ext - r_t0;
                if (div_rsp.done) r_t1 <= div_rsp.quot[BLK_W-1:0];
            end
            S_W3: begin
                r_dt <= r_t1 - r_t0;
                if (div_rsp.done) r_s1 <= div_rsp.rem[SPT_W-1:0];
            end
            S_W4: begin
                // (s0 - cur) mod spt, both already below spt
                if (div_rsp.done) begin
                    r_diff <= (r_s0 >= cur_sector) ? r_s0 - cur_sector
                        : SPT_W'((SPT_W+1)'(r_s0) + (SPT_W+1)'(spt_eff)
                                 - (SPT_W+1)'(cur_sector));
                end
            end
            S_M2: r_near <= r_prod;  // hop * track seek, held until far seek is ready
            S_M3: r_acc <= ACC_W'(r_prod);  // track hops inside request
            S_W5: if (div_rsp.done) r_acc <= r_acc + ACC_W'(seek);
            S_W6: if (div_rsp.done) r_acc <= r_acc + ACC_W'(div_rsp.quot[TIME_W-1:0]);
            S_W7: if (div_rsp.done) r_acc <= r_acc + ACC_W'(div_rsp.quot[TIME_W+CNT_W-1:0]);
            default: ;
        endcase
    end

    // head moves only on a served request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_track  <= '0;
            r_head_sector <= '0;
        end else if (out_load && !r_status) begin
            r_head_track  <= r_t1[TRACK_BITS-1:0];
            r_head_sector <= SECTOR_BITS'(r_s1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= r_status;
            r_out_time   <= (|r_acc[ACC_W-1:OUT_W]) ? {OUT_W{1'b1}} : r_acc[OUT_W-1:0];
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.access_time = r_out_time;

endmodule

// ----- rtl/dat_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
module dat_div import dat_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DIVD_W-1:0] r_q;
    logic [DVSR_W-1:0] r_r;
    logic [DVSR_W-1:0] r_dvsr;

    logic [DVSR_W:0] trial;
    logic [DVSR_W:0] sub;
    logic            ge;

    assign trial = {r_r, r_q[DIVD_W-1]};
    assign ge    = trial >= {1'b0, r_dvsr};
    assign sub   = trial - {1'b0, r_dvsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend arrives left-aligned, quotient bits fill from the bottom
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q    <= i_req.dividend;
            r_r    <= '0;
            r_dvsr <= i_req.divisor;
        end else if (r_busy) begin
            r_q <= {r_q[DIVD_W-2:0], ge};
            r_r <= ge ? sub[DVSR_W-1:0] : trial[DVSR_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_r;

endmodule
